>>> rtl/clock_average_delta_engine_defines.svh
// ----------------------------------------------------------------------------
// clock average delta engine assertion macros
// shared concurrent assertion forms, sampled on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef CLOCK_AVERAGE_DELTA_ENGINE_DEFINES_SVH
`define CLOCK_AVERAGE_DELTA_ENGINE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define CADE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CADE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cade_pkg.sv
// ----------------------------------------------------------------------------
// cade_pkg
// shared widths, state encoding and status types of the clock average engine
// ----------------------------------------------------------------------------
package cade_pkg;

    localparam int TIME_W    = 17;
    localparam int CORR_W    = 18;
    localparam int S_TDATA_W = ((TIME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CORR_W + TIME_W + 7) / 8) * 8;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_RD   = 6'b001000,
        ST_LD   = 6'b010000,
        ST_SRV  = 6'b100000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/cade_store.sv
// ----------------------------------------------------------------------------
// cade_store
// reading store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cade_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [cade_pkg::TIME_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [cade_pkg::TIME_W-1:0] o_rd_data
);
    import cade_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/cade_div.sv
// ----------------------------------------------------------------------------
// cade_div
// restoring divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module cade_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DVD_W-1:0]      i_dividend,
    input  logic [DVS_W-1:0]      i_divisor,
    output logic [DVD_W-1:0]      o_quotient,
    output cade_pkg::t_div_stat   o_stat
);
    import cade_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> rtl/clock_average_delta_engine.sv
// ----------------------------------------------------------------------------
// clock_average_delta_engine
// averaging step of clock synchronisation: stores client readings, then
// returns each clock's correction towards the average
// ----------------------------------------------------------------------------
// A reading request is stored in an on-chip memory of
// MAX_CLIENTS entries; further readings in a full round are dropped. Once the
// request marked tlast is taken, the engine starts the divider, runs the
// bit-serial divider and takes the quotient, then walks the memory, reading
// and loading the result of each stored reading, and last loads the server
// result; the walk and the server result wait while the output side does
// not take results. A new round
// is taken once the server result sits in the output register.
// ----------------------------------------------------------------------------
module clock_average_delta_engine #(
    parameter int MAX_CLIENTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [cade_pkg::TIME_W-1:0]       i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [16:0] client_time, rest zero
    input  logic [cade_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [17:0] correction, [34:18] synced_time, rest zero
    output logic [cade_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] is_server
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import cade_pkg::*;

    `include "clock_average_delta_engine_defines.svh"

    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int ADDR_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int DVS_W  = $clog2(MAX_CLIENTS + 2);
    localparam int DVD_W  = TIME_W + CNT_W;

    t_state              r_state;
    t_state              n_state;
    logic [TIME_W-1:0]   r_server;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [DVD_W-1:0]    r_sum;
    logic [TIME_W-1:0]   r_avg;

    logic                r_out_valid;
    logic [CORR_W-1:0]   r_out_corr;
    logic [TIME_W-1:0]   r_out_avg;
    logic                r_out_srv;
    logic                r_out_last;

    logic                w_in_acc;
    logic                w_room;
    logic                w_out_free;
    logic                w_wr_en;
    logic [TIME_W-1:0]   w_reading;
    logic [TIME_W-1:0]   w_rd_data;
    logic [DVD_W-1:0]    w_quotient;
    t_div_stat           w_div_stat;
    logic                w_last_idx;
    logic                w_load_cli;
    logic                w_load_srv;

    assign w_reading     = s_axis_tdata[TIME_W-1:0];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_room        = r_count < CNT_W'(MAX_CLIENTS);
    assign w_wr_en       = w_in_acc && w_room;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_last_idx    = (r_idx + CNT_W'(1)) == r_count;
    assign w_load_cli    = (r_state == ST_LD) && w_out_free;
    assign w_load_srv    = (r_state == ST_SRV) && w_out_free;

    cade_store #(
        .DEPTH  (MAX_CLIENTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (w_reading),
        .i_rd_en   (r_state == ST_RD),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    cade_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_LOAD),
        .i_dividend (r_sum + DVD_W'(r_server)),
        .i_divisor  (DVS_W'(r_count) + DVS_W'(1)),
        .o_quotient (w_quotient),
        .o_stat     (w_div_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:  n_state = ST_LD;
            ST_LD: begin
                if (w_out_free) begin
                    n_state = w_last_idx ? ST_SRV : ST_RD;
                end
            end
            ST_SRV: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_server    <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_server <= i_cfg_wr_data;
            end
            if (w_wr_en) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + DVD_W'(w_reading);
            end
            if (w_load_cli) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (w_load_srv) begin
                r_count <= '0;
                r_sum   <= '0;
                r_idx   <= '0;
            end
            if (w_load_cli || w_load_srv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_div_stat.done) begin
            r_avg <= w_quotient[TIME_W-1:0];
        end
        if (w_load_cli) begin
            r_out_corr <= {1'b0, r_avg} - {1'b0, w_rd_data};
            r_out_avg  <= r_avg;
            r_out_srv  <= 1'b0;
            r_out_last <= 1'b0;
        end else if (w_load_srv) begin
            r_out_corr <= {1'b0, r_avg} - {1'b0, r_server};
            r_out_avg  <= r_avg;
            r_out_srv  <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - CORR_W - TIME_W)'(0), r_out_avg, r_out_corr};
    assign m_axis_tuser  = r_out_srv;
    assign m_axis_tlast  = r_out_last;

    `CADE_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_CLIENTS), "count beyond store size")
    `CADE_ASSERT_NEXT(a_div_to_walk, (r_state == ST_DIV) && w_div_stat.done, r_state == ST_RD, "walk did not follow division")
    `CADE_ASSERT_SAME(a_walk_index, (r_state == ST_RD) || (r_state == ST_LD), r_idx < r_count, "walk index past stored readings")
    `CADE_ASSERT_SAME(a_busy_div, r_state == ST_DIV, w_div_stat.busy || w_div_stat.done, "divider idle during division")

endmodule

>>> tb/sv/tb_clock_average_delta_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_average_delta_engine
// self-checking bench for the clock averaging step: client readings are sent
// as rounds, each closed by tlast, and every returned correction is compared
// against a scoreboard that keeps its own store, sum and server register
// ----------------------------------------------------------------------------
module tb_clock_average_delta_engine;
    import cade_pkg::*;

    localparam int N_SLOTS = 32;
    localparam int SETTLE  = 40;

    typedef struct packed {
        logic [CORR_W-1:0] correction;
        logic [TIME_W-1:0] synced;
        logic              is_server;
        logic              last;
    } t_corr;

    class correction_board;
        logic [TIME_W-1:0] server_reg;
        logic [TIME_W-1:0] slot [N_SLOTS];
        int                fill;
        logic [31:0]       total;
        t_corr             pending_corrections[$];
        int                errors;
        int                rounds;
        int                checked;
        int                dropped;

        function new();
            server_reg = '0;
            fill       = 0;
            total      = '0;
            errors     = 0;
            rounds     = 0;
            checked    = 0;
            dropped    = 0;
        endfunction

        function void set_server(logic [TIME_W-1:0] value);
            server_reg = value;
        endfunction

        function t_corr correction_of(logic [31:0] avg, logic [TIME_W-1:0] reading,
                                      logic srv);
            t_corr       c;
            logic [31:0] diff;
            diff         = avg - {15'd0, reading};
            c.correction = diff[CORR_W-1:0];
            c.synced     = avg[TIME_W-1:0];
            c.is_server  = srv;
            c.last       = srv;
            return c;
        endfunction

        function void take_reading(logic [TIME_W-1:0] reading, logic closes);
            logic [31:0] avg;
            int          k;
            if (fill < N_SLOTS) begin
                slot[fill] = reading;
                fill++;
                total += {15'd0, reading};
            end else begin
                dropped++;
            end
            if (closes) begin
                avg = (total + {15'd0, server_reg}) / 32'(fill + 1);
                for (k = 0; k < fill; k++)
                    pending_corrections.push_back(correction_of(avg, slot[k], 1'b0));
                pending_corrections.push_back(correction_of(avg, server_reg, 1'b1));
                fill  = 0;
                total = '0;
                rounds++;
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch in %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task match_correction(logic [M_TDATA_W-1:0] data, logic user, logic lst);
            t_corr want;
            if (pending_corrections.size() == 0) begin
                report("unrequested result", data, 0);
                return;
            end
            want = pending_corrections.pop_front();
            checked++;
            if (data[CORR_W-1:0] !== want.correction)
                report("correction", data[CORR_W-1:0], want.correction);
            if (data[CORR_W+TIME_W-1:CORR_W] !== want.synced)
                report("synced_time", data[CORR_W+TIME_W-1:CORR_W], want.synced);
            if (user !== want.is_server)
                report("is_server", user, want.is_server);
            if (lst !== want.last)
                report("last_result", lst, want.last);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [TIME_W-1:0]    i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // [16:0] client_time, rest zero
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [17:0] correction, [34:18] synced_time, rest zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] is_server
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    correction_board board = new();
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;
    int sent        = 0;

    clock_average_delta_engine #(
        .MAX_CLIENTS (N_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[clock_average_delta_engine] ERROR");
        $finish;
    end

    function automatic logic [TIME_W-1:0] pick_reading();
        if ($urandom_range(0, 3) == 0)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(0, 86399));
    endfunction

    task automatic write_server(logic [TIME_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.set_server(value);
    endtask

    task automatic send_reading(logic [TIME_W-1:0] reading, logic closes);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(reading);
        s_axis_tlast  <= closes;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_reading(reading, closes);
        sent++;
    endtask

    task automatic send_round(int len);
        int k;
        for (k = 0; k < len; k++)
            send_reading(pick_reading(), k == len - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_corrections.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // result side
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                take_steady = !take_steady;
            gap = take_steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.match_correction(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // request side
    initial begin
        int phase;
        int phase_items;
        int len;
        int k;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge readings with the server at zero
        write_server('0);
        send_reading('0, 1'b1);
        send_reading(17'h1FFFF, 1'b1);
        send_reading(17'd86399, 1'b0);
        send_reading('0, 1'b0);
        send_reading(17'h1FFFF, 1'b0);
        send_reading(17'd1, 1'b1);
        for (k = 0; k < 8; k++)
            send_reading((k % 3 == 0) ? 17'h1FFFF : (k % 3 == 1) ? 17'd0 : pick_reading(),
                         k == 7);
        drain();

        for (phase = 1; phase <= 3; phase++) begin
            case (phase)
                1: write_server(17'h1FFFF);
                2: write_server(TIME_W'($urandom));
                default: write_server(17'd86399);
            endcase
            phase_items = 0;
            while (phase_items < 36) begin
                // odd phases open with a round that overflows the store
                if (phase_items == 0 && phase != 2)
                    len = $urandom_range(N_SLOTS + 1, N_SLOTS + 4);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(N_SLOTS - 2, N_SLOTS + 4);
                else
                    len = $urandom_range(1, 6);
                send_round(len);
                phase_items += len;
            end
            drain();
        end

        $display("sent %0d readings in %0d rounds, %0d dropped on a full store",
                 sent, board.rounds, board.dropped);
        $display("checked %0d corrections across four server settings", board.checked);
        if (board.errors == 0)
            $display("[clock_average_delta_engine] OK");
        else
            $display("[clock_average_delta_engine] ERROR");
        $finish;
    end

endmodule
